### rtl/tmlr_pkg.sv
package tmlr_pkg;

    // geometry of the map and the tile stores
    localparam int TILES_ACROSS = 30;
    localparam int TILE_ROWS    = 28;
    localparam int TILE_W       = 8;
    localparam int TILE_H       = 8;
    localparam int RAM_TILE_CNT = 32;

    localparam int TILE_BYTES = TILE_W * TILE_H;
    localparam int MAP_CELLS  = TILES_ACROSS * TILE_ROWS;
    localparam int ROM_TILES  = 256 - RAM_TILE_CNT;
    localparam int RAM_BYTES  = RAM_TILE_CNT * TILE_BYTES;
    localparam int ROM_BYTES  = ROM_TILES * TILE_BYTES;

    // address and index widths
    localparam int MAP_AW  = $clog2(MAP_CELLS);
    localparam int RAM_AW  = $clog2(RAM_BYTES);
    localparam int ROM_AW  = $clog2(ROM_BYTES);
    localparam int ADDR_W  = (ROM_AW > RAM_AW) ? ((ROM_AW > MAP_AW) ? ROM_AW : MAP_AW)
                                               : ((RAM_AW > MAP_AW) ? RAM_AW : MAP_AW);
    localparam int IDX_W   = $clog2(TILE_W);
    localparam int TLINE_W = (TILE_H > 1) ? $clog2(TILE_H) : 1;

    // command queue depth
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // request type codes
    typedef enum logic [2:0] {
        REQ_SET_ROM_CELL = 3'd0,
        REQ_SET_RAW_CELL = 3'd1,
        REQ_WRITE_RAM    = 3'd2,
        REQ_WRITE_ROM    = 3'd3,
        REQ_RENDER       = 3'd4
    } t_req_type;

    // decoded command kinds
    typedef enum logic [1:0] {
        CMD_MAP_WR = 2'd0,
        CMD_RAM_WR = 2'd1,
        CMD_ROM_WR = 2'd2,
        CMD_RENDER = 2'd3
    } t_cmd_kind;

    typedef struct packed {
        logic [2:0] req_type;
        logic [4:0] column;
        logic [4:0] row;
        logic [7:0] scan_line;
        logic [7:0] tile_number;
        logic [5:0] byte_offset;
        logic [7:0] value;
    } t_request;

    typedef struct packed {
        logic [7:0] pixel;
        logic [7:0] pixel_x;
        logic       last;
    } t_result;

    // command passed from front to back
    typedef struct packed {
        t_cmd_kind          kind;
        logic [ADDR_W-1:0]  addr;
        logic [7:0]         data;
        logic [4:0]         column;
        logic [TLINE_W-1:0] tline;
        logic               ok;
    } t_cmd;

endpackage

### rtl/tmlr_front.sv
module tmlr_front (
    input  tmlr_pkg::t_request i_req,
    output logic               o_keep,
    output tmlr_pkg::t_cmd     o_cmd
);
    import tmlr_pkg::*;

    logic [7:0] mrow;
    logic       map_ok;
    logic       rend_ok;

    // range checks shared by map writes and renders
    always_comb begin
        mrow    = 8'(i_req.scan_line / TILE_H);
        map_ok  = (int'(i_req.column) < TILES_ACROSS) && (int'(i_req.row) < TILE_ROWS);
        rend_ok = (int'(i_req.column) < TILES_ACROSS) && (int'(mrow) < TILE_ROWS);
    end

    // classify the request into a back-end command
    always_comb begin
        o_keep       = 1'b0;
        o_cmd.kind   = CMD_MAP_WR;
        o_cmd.addr   = '0;
        o_cmd.data   = i_req.value;
        o_cmd.column = i_req.column;
        o_cmd.tline  = TLINE_W'(i_req.scan_line % TILE_H);
        o_cmd.ok     = 1'b0;
        unique case (i_req.req_type)
            REQ_SET_ROM_CELL, REQ_SET_RAW_CELL: begin
                o_keep     = map_ok;
                o_cmd.kind = CMD_MAP_WR;
                o_cmd.addr = ADDR_W'(int'(i_req.row) * TILES_ACROSS + int'(i_req.column));
                if (i_req.req_type == REQ_SET_ROM_CELL) begin
                    o_cmd.data = 8'(int'(i_req.value) + RAM_TILE_CNT);
                end
            end
            REQ_WRITE_RAM: begin
                o_keep     = (int'(i_req.tile_number) < RAM_TILE_CNT) &&
                             (int'(i_req.byte_offset) < TILE_BYTES);
                o_cmd.kind = CMD_RAM_WR;
                o_cmd.addr = ADDR_W'(int'(i_req.tile_number) * TILE_BYTES +
                                     int'(i_req.byte_offset));
            end
            REQ_WRITE_ROM: begin
                o_keep     = (int'(i_req.tile_number) < ROM_TILES) &&
                             (int'(i_req.byte_offset) < TILE_BYTES);
                o_cmd.kind = CMD_ROM_WR;
                o_cmd.addr = ADDR_W'(int'(i_req.tile_number) * TILE_BYTES +
                                     int'(i_req.byte_offset));
            end
            REQ_RENDER: begin
                o_keep     = 1'b1;
                o_cmd.kind = CMD_RENDER;
                o_cmd.ok   = rend_ok;
                if (rend_ok) begin
                    o_cmd.addr = ADDR_W'(int'(mrow) * TILES_ACROSS + int'(i_req.column));
                end
            end
            default: begin
                o_keep = 1'b0;
            end
        endcase
    end

endmodule

### rtl/tmlr_queue.sv
module tmlr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tmlr_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output tmlr_pkg::t_cmd o_head,
    output logic           o_empty,
    output logic           o_full
);
    import tmlr_pkg::*;

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_head  = r_slot[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= QPTR_W'((int'(r_wr_ptr) + 1) % QUEUE_DEPTH);
            end
            if (i_pop) begin
                r_rd_ptr <= QPTR_W'((int'(r_rd_ptr) + 1) % QUEUE_DEPTH);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // command slots
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### rtl/tmlr_back.sv
module tmlr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tmlr_pkg::t_cmd    i_head,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_clearing,
    output logic              o_res_strobe,
    output tmlr_pkg::t_result o_res
);
    import tmlr_pkg::*;

    // stores
    logic [7:0] r_map [MAP_CELLS];
    logic [7:0] r_ram [RAM_BYTES];
    logic [7:0] r_rom [ROM_BYTES];

    // map clearing sweep
    logic              r_clearing;
    logic [MAP_AW-1:0] r_clr_cnt;

    // map lookup stage
    logic               r_s1_vld;
    logic [4:0]         r_s1_col;
    logic [TLINE_W-1:0] r_s1_tline;
    logic               r_s1_ok;
    logic [7:0]         r_map_q;

    // pixel sequencer
    logic              r_seq_act;
    logic [IDX_W-1:0]  r_seq_idx;
    logic              r_seq_ram;
    logic              r_seq_ok;
    logic [4:0]        r_seq_col;
    logic [ADDR_W-1:0] r_seq_base;

    // output stage
    logic       r_o_vld;
    logic       r_o_ram;
    logic       r_o_ok;
    logic [7:0] r_o_x;
    logic       r_o_last;
    logic [7:0] r_ram_q;
    logic [7:0] r_rom_q;

    logic              head_vld;
    logic              seq_last;
    logic              s1_move;
    logic              n_seq_ram;
    logic [ADDR_W-1:0] n_seq_base;
    logic [ADDR_W-1:0] rd_addr;
    logic              map_we;
    logic [MAP_AW-1:0] map_wa;
    logic [7:0]        map_wd;

    assign o_clearing = r_clearing;
    assign head_vld   = !i_empty && !r_clearing;
    assign seq_last   = r_seq_act && (r_seq_idx == IDX_W'(TILE_W - 1));
    assign s1_move    = r_s1_vld && (!r_seq_act || seq_last);
    assign rd_addr    = r_seq_base + ADDR_W'(r_seq_idx);

    // pop decision per command kind
    always_comb begin
        o_pop = 1'b0;
        unique case (i_head.kind) inside
            CMD_MAP_WR: begin
                o_pop = head_vld;
            end
            CMD_RAM_WR, CMD_ROM_WR: begin
                o_pop = head_vld && !r_s1_vld && (!r_seq_act || seq_last);
            end
            CMD_RENDER: begin
                o_pop = head_vld && (!r_s1_vld || s1_move);
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    // tile base address from the fetched map entry
    always_comb begin
        n_seq_ram = (int'(r_map_q) < RAM_TILE_CNT);
        if (n_seq_ram) begin
            n_seq_base = ADDR_W'(int'(r_map_q) * TILE_BYTES + int'(r_s1_tline) * TILE_W);
        end else begin
            n_seq_base = ADDR_W'((int'(r_map_q) - RAM_TILE_CNT) * TILE_BYTES +
                                 int'(r_s1_tline) * TILE_W);
        end
    end

    // map write port: clearing sweep or map write command
    always_comb begin
        if (r_clearing) begin
            map_we = 1'b1;
            map_wa = r_clr_cnt;
            map_wd = 8'(RAM_TILE_CNT);
        end else begin
            map_we = o_pop && (i_head.kind == CMD_MAP_WR);
            map_wa = i_head.addr[MAP_AW-1:0];
            map_wd = i_head.data;
        end
    end

    // clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clearing) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == MAP_AW'(MAP_CELLS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // tile map memory, entry held while the render waits in the lookup stage
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map[map_wa] <= map_wd;
        end
        if (o_pop && (i_head.kind == CMD_RENDER)) begin
            r_map_q <= r_map[i_head.addr[MAP_AW-1:0]];
        end
    end

    // ram tile store
    always_ff @(posedge i_clk) begin
        if (o_pop && (i_head.kind == CMD_RAM_WR)) begin
            r_ram[i_head.addr[RAM_AW-1:0]] <= i_head.data;
        end
        r_ram_q <= r_ram[rd_addr[RAM_AW-1:0]];
    end

    // rom tile store
    always_ff @(posedge i_clk) begin
        if (o_pop && (i_head.kind == CMD_ROM_WR)) begin
            r_rom[i_head.addr[ROM_AW-1:0]] <= i_head.data;
        end
        r_rom_q <= r_rom[rd_addr[ROM_AW-1:0]];
    end

    // map lookup stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_pop && (i_head.kind == CMD_RENDER)) begin
            r_s1_vld <= 1'b1;
        end else if (s1_move) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && (i_head.kind == CMD_RENDER)) begin
            r_s1_col   <= i_head.column;
            r_s1_tline <= i_head.tline;
            r_s1_ok    <= i_head.ok;
        end
    end

    // pixel sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_act <= 1'b0;
            r_seq_idx <= '0;
        end else if (s1_move) begin
            r_seq_act <= 1'b1;
            r_seq_idx <= '0;
        end else if (r_seq_act) begin
            r_seq_act <= !seq_last;
            r_seq_idx <= r_seq_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_seq_ram  <= n_seq_ram;
            r_seq_ok   <= r_s1_ok;
            r_seq_col  <= r_s1_col;
            r_seq_base <= n_seq_base;
        end
    end

    // output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= r_seq_act;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_ram  <= r_seq_ram;
        r_o_ok   <= r_seq_ok;
        r_o_x    <= 8'(int'(r_seq_col) * TILE_W + int'(r_seq_idx));
        r_o_last <= seq_last;
    end

    assign o_res_strobe  = r_o_vld;
    assign o_res.pixel   = r_o_ok ? (r_o_ram ? r_ram_q : r_rom_q) : 8'd0;
    assign o_res.pixel_x = r_o_x;
    assign o_res.last    = r_o_last;

endmodule

### rtl/tile_map_line_renderer_unit.sv
// channel    signals                  handshake
// request    start, busy, i_req       taken when start is high and busy is low
// result     o_res_strobe, o_res      one pixel per strobe, no back pressure
//
// A render request yields eight pixels on consecutive cycles; after it leaves
// the command queue it passes the map lookup stage, the pixel sequencer and
// the output stage, and the next render's map lookup overlaps the current tile.
// A tile store write waits until the sequencer has finished reading for
// earlier renders.
// After reset busy stays high while all 840 tile map entries are swept to ROM
// tile 0; afterwards busy is high only while the four-entry command queue is full.
module tile_map_line_renderer_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  tmlr_pkg::t_request i_req,
    output logic               o_res_strobe,
    output tmlr_pkg::t_result  o_res
);
    import tmlr_pkg::*;

    logic clearing;
    logic keep;
    logic q_full;
    logic q_empty;
    logic q_pop;
    t_cmd front_cmd;
    t_cmd head_cmd;

    assign busy = clearing || q_full;

    // request decode
    tmlr_front u_front (
        .i_req  (i_req),
        .o_keep (keep),
        .o_cmd  (front_cmd)
    );

    // command queue between front and back
    tmlr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (start && !busy && keep),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_head  (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // execution: stores, map lookup and pixel sequencer
    tmlr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head_cmd),
        .i_empty      (q_empty),
        .o_pop        (q_pop),
        .o_clearing   (clearing),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res)
    );

endmodule
